>>> rtl/rq_pkg.sv
package rq_pkg;

    localparam int DATA_BITS  = 32;
    localparam int INDEX_BITS = 4;
    localparam int COUNT_BITS = 4;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_COUNT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_mode                 mode;
        logic [DATA_BITS-1:0]  data_in;
        logic [INDEX_BITS-1:0] index;
    } t_cmd;

    typedef struct packed {
        logic [DATA_BITS-1:0]  data_out;
        t_status               status;
        logic [COUNT_BITS-1:0] count;
    } t_result;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

>>> rtl/ring_queue_with_indexed_peek_core.sv
// Ring queue with indexed peek.
// Holds up to SLOTS-1 words of min(WORD_BITS, DATA_BITS) bits in cells; the oldest
// word sits in the first cell and a pop shifts every cell toward it by one.
// Command channel: i_cmd is taken at a rising edge with start high and busy
// low. Modes: push, pop, peek at an offset from the oldest word, count query.
// Result channel: o_result is shown for exactly one cycle with o_done high,
// in the cycle after the command is taken. It carries the popped or peeked word
// (zero otherwise), a status (ok, full, empty, index out of range) and the
// number of words held after the command.
// Throughput: one command per cycle; busy is high during reset and in the
// first cycle after it, and low otherwise. The result is registered.
// Reset (synchronous, active low) empties the queue; cell contents are not
// cleared and are never read before being written.
// The receiver cannot stall: every result must be taken when o_done is high.
module ring_queue_with_indexed_peek_core
    import rq_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    localparam int CELLS = SLOTS - 1;
    localparam int CW    = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;
    localparam int CNTW  = $clog2(SLOTS);
    localparam int CMPW  = (CNTW > INDEX_BITS) ? CNTW : INDEX_BITS;

    logic            r_up;
    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] n_count;
    logic            r_done;
    t_result         r_result;
    t_result         n_result;
    t_cell_ctl       w_ctl;
    logic            w_accept;
    logic            w_empty;
    logic            w_full;
    logic [CW-1:0]   w_word;
    logic [CW-1:0]   w_peek;
    logic [CMPW-1:0] w_index;
    logic [CMPW-1:0] w_count;
    logic [CELLS-1:0]        w_valid;
    logic [CELLS-1:0][CW-1:0] w_data;

    assign busy     = !r_up;
    assign w_accept = start && !busy;
    assign w_empty  = !w_valid[0];
    assign w_full   = w_valid[CELLS-1];
    assign w_word   = i_cmd.data_in[CW-1:0];
    assign w_index  = CMPW'(i_cmd.index);
    assign w_count  = CMPW'(r_count);

    genvar g;
    generate
        for (g = 0; g < CELLS; g++) begin : g_cell
            logic          w_prev_valid;
            logic          w_next_valid;
            logic [CW-1:0] w_next_data;
            if (g == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_mid
                assign w_prev_valid = w_valid[g-1];
            end
            if (g == CELLS - 1) begin : g_last
                assign w_next_valid = 1'b0;
                assign w_next_data  = '0;
            end else begin : g_body
                assign w_next_valid = w_valid[g+1];
                assign w_next_data  = w_data[g+1];
            end
            rq_cell #(
                .WIDTH(CW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_prev_valid(w_prev_valid),
                .i_next_valid(w_next_valid),
                .i_next_data (w_next_data),
                .i_word      (w_word),
                .o_valid     (w_valid[g]),
                .o_data      (w_data[g])
            );
        end
    endgenerate

    always_comb begin
        w_peek = '0;
        for (int i = 0; i < CELLS; i++) begin
            if (w_index == CMPW'(i)) begin
                w_peek = w_data[i];
            end
        end
    end

    always_comb begin
        w_ctl             = '0;
        n_count           = r_count;
        n_result.data_out = '0;
        n_result.status   = ST_OK;
        unique case (i_cmd.mode)
            MODE_PUSH: begin
                if (w_full) begin
                    n_result.status = ST_FULL;
                end else begin
                    w_ctl.push = w_accept;
                    n_count    = r_count + 1'b1;
                end
            end
            MODE_POP: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    w_ctl.pop         = w_accept;
                    n_count           = r_count - 1'b1;
                    n_result.data_out = DATA_BITS'(w_data[0]);
                end
            end
            MODE_PEEK: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else if (w_index >= w_count) begin
                    n_result.status = ST_RANGE;
                end else begin
                    n_result.data_out = DATA_BITS'(w_peek);
                end
            end
            MODE_COUNT: begin
            end
            default: begin
            end
        endcase
        n_result.count = COUNT_BITS'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up    <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_up   <= 1'b1;
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("result strobe without an accepted command");

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("entry count disagrees with occupied cells");

    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> (int'(r_count) == CELLS))
        else $error("full status below capacity");

endmodule

>>> rtl/rq_cell.sv
module rq_cell
    import rq_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_prev_valid,
    input  logic             i_next_valid,
    input  logic [WIDTH-1:0] i_next_data,
    input  logic [WIDTH-1:0] i_word,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;
    logic             w_load;

    assign w_load = i_ctl.push && !r_valid && i_prev_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.pop) begin
            r_valid <= i_next_valid;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_data <= i_next_data;
        end else if (w_load) begin
            r_data <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> test/queue_shadow_pkg.sv
`timescale 1ns / 100ps
package queue_shadow_pkg;
    import rq_pkg::*;

    localparam int SLOTS      = 16;
    localparam int PRINT_CAP  = 100;

    class queue_shadow;
        logic [DATA_BITS-1:0] slot_mem [SLOTS];
        int unsigned          wr_ptr;
        int unsigned          rd_ptr;
        t_result              due_q [$];
        int                   errors;

        function new();
            wr_ptr = 0;
            rd_ptr = 0;
            errors = 0;
        endfunction

        function int unsigned held();
            return (wr_ptr + SLOTS - rd_ptr) % SLOTS;
        endfunction

        function void take_word(t_cmd c);
            t_result     r;
            int unsigned n;
            r.data_out = '0;
            r.status   = ST_OK;
            n          = held();
            case (c.mode)
                MODE_PUSH: begin
                    if ((wr_ptr + 1) % SLOTS == rd_ptr) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_mem[wr_ptr] = c.data_in;
                        wr_ptr           = (wr_ptr + 1) % SLOTS;
                    end
                end
                MODE_POP: begin
                    if (n == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data_out = slot_mem[rd_ptr];
                        rd_ptr     = (rd_ptr + 1) % SLOTS;
                    end
                end
                MODE_PEEK: begin
                    if (n == 0) begin
                        r.status = ST_EMPTY;
                    end else if (c.index >= n) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.data_out = slot_mem[(rd_ptr + c.index) % SLOTS];
                    end
                end
                default: begin
                end
            endcase
            r.count = COUNT_BITS'(held());
            due_q.push_back(r);
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_word(t_result got);
            t_result want;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected word data=%h status=%0d count=%0d",
                                 got.data_out, got.status, got.count));
                return;
            end
            want = due_q.pop_front();
            if (got.data_out !== want.data_out) begin
                report($sformatf("data_out %h, want %h", got.data_out, want.data_out));
            end
            if (got.status !== want.status) begin
                report($sformatf("status %0d, want %0d", got.status, want.status));
            end
            if (got.count !== want.count) begin
                report($sformatf("count %0d, want %0d", got.count, want.count));
            end
        endtask
    endclass

endpackage

>>> test/tb.sv
`timescale 1ns / 100ps
module tb;
    import rq_pkg::*;
    import queue_shadow_pkg::*;

    localparam int IDLE_LIMIT   = 200;
    localparam int RANDOM_WORDS = 1675;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_done;
    t_result o_result;

    queue_shadow shadow = new();
    int          level = 0;
    int          pace = 0;
    int          idle_cycles = 0;

    ring_queue_with_indexed_peek_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                shadow.check_word(o_result);
            end
            if (start && !busy) begin
                shadow.take_word(i_cmd);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        case (pace)
            0: begin
                return 0;
            end
            1: begin
                return $urandom_range(0, 6);
            end
            default: begin
                return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
            end
        endcase
    endfunction

    function automatic logic [INDEX_BITS-1:0] pick_index();
        if (level > 0 && $urandom_range(0, 3) != 0) begin
            return INDEX_BITS'($urandom_range(0, level - 1));
        end
        return INDEX_BITS'($urandom_range(0, 15));
    endfunction

    task automatic send(input t_mode m, input logic [INDEX_BITS-1:0] idx,
                        input logic [DATA_BITS-1:0] data);
        t_cmd c;
        int   gap;
        c.mode    = m;
        c.data_in = data;
        c.index   = idx;
        gap       = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        case (m)
            MODE_PUSH: begin
                if (level < SLOTS - 1) level++;
            end
            MODE_POP: begin
                if (level > 0) level--;
            end
            default: begin
            end
        endcase
    endtask

    // hold off until every outstanding word has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (shadow.due_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int    issued;
        int    len;
        int    kind;
        int    k;
        int    r;
        t_mode m;
        issued = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pace = 1;
        send(MODE_POP, 4'h0, $urandom);
        send(MODE_PEEK, 4'hF, $urandom);
        send(MODE_COUNT, 4'h5, $urandom);
        send(MODE_PUSH, 4'h0, 32'h0000_0000);
        send(MODE_PUSH, 4'hF, 32'hFFFF_FFFF);
        send(MODE_PEEK, 4'h1, $urandom);
        send(MODE_PEEK, 4'h2, $urandom);
        send(MODE_POP, 4'hA, $urandom);
        repeat (14) send(MODE_PUSH, INDEX_BITS'($urandom_range(0, 15)), $urandom);
        send(MODE_PUSH, 4'h3, $urandom);
        send(MODE_PEEK, 4'hE, $urandom);
        send(MODE_PEEK, 4'hF, $urandom);
        send(MODE_COUNT, 4'h0, $urandom);
        drain();

        while (issued < RANDOM_WORDS) begin
            kind = $urandom_range(0, 9);
            pace = $urandom_range(0, 2);
            len  = $urandom_range(4, 30);
            for (k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (kind <= 2) begin
                    m = (r < 20) ? MODE_PEEK : MODE_PUSH;
                end else if (kind <= 4) begin
                    m = (r < 10) ? MODE_PEEK : MODE_POP;
                end else if (kind <= 8) begin
                    if (r < 35) m = MODE_PUSH;
                    else if (r < 65) m = MODE_POP;
                    else if (r < 90) m = MODE_PEEK;
                    else m = MODE_COUNT;
                end else begin
                    m = t_mode'($urandom_range(0, 3));
                end
                send(m, pick_index(), $urandom);
            end
            issued += len;
            if ($urandom_range(0, 11) == 0) begin
                drain();
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.due_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
